[rtl/core/cda_pkg.sv]
// Shared types, constants and the control store for the calendar date block.
// Holds request/response payloads, sequencer codes and the month length table.
// Depends on nothing.
`timescale 1ns / 1ps

package cda_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ADD_W   = 16;
    localparam int CNT_W   = 10;
    localparam int WDAY_W  = ADD_W + 1;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int QUOT_W  = 12;
    localparam int MOD_W   = 5;

    localparam logic [APB_AW-1:0] REG_MAX_DIFFERENCE = 3'd0;
    localparam logic [CNT_W-1:0]  MAX_DIFFERENCE_RST = 10'd365;

    // year / 25 by reciprocal: (y * DIV25_MUL) >> DIV25_SHIFT, exact for 16-bit y
    localparam logic [32:0]       DIV25_MUL   = 33'd83887;
    localparam int                DIV25_SHIFT = 21;
    localparam logic [MOD_W-1:0]  MOD25_LAST  = 5'd24;
    localparam logic [YEAR_W-1:0] YEAR_DIV    = 16'd25;

    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_APR = 4'd4;
    localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] M_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_28 = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_31 = 5'd31;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DIFF = 1'b1;

    typedef struct packed {
        logic               command;
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        logic [ADD_W-1:0]   days_to_add;
    } t_in_data;

    typedef struct packed {
        logic [DAY_W-1:0]   result_day;
        logic [MONTH_W-1:0] result_month;
        logic [YEAR_W-1:0]  result_year;
        logic [CNT_W-1:0]   day_count;
        logic               year_overflow;
    } t_out_data;

    typedef enum logic [2:0] {
        S_WAIT  = 3'd0,
        S_QUOT  = 3'd1,
        S_MOD   = 3'd2,
        S_AWALK = 3'd3,
        S_DCHK  = 3'd4,
        S_DSTEP = 3'd5,
        S_EMIT  = 3'd6
    } t_step;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_QUOT,
        OP_MOD,
        OP_WALK,
        OP_STEP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_REQ,
        C_DIFF,
        C_FITS,
        C_DATE_EQ,
        C_STEP_DONE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jt;
        t_step jf;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '{op: OP_NOP, cond: C_ALWAYS, jt: S_WAIT, jf: S_WAIT};
        unique case (s)
            S_WAIT:  c = '{op: OP_LOAD, cond: C_REQ,       jt: S_QUOT,  jf: S_WAIT};
            S_QUOT:  c = '{op: OP_QUOT, cond: C_ALWAYS,    jt: S_MOD,   jf: S_MOD};
            S_MOD:   c = '{op: OP_MOD,  cond: C_DIFF,      jt: S_DCHK,  jf: S_AWALK};
            S_AWALK: c = '{op: OP_WALK, cond: C_FITS,      jt: S_EMIT,  jf: S_AWALK};
            S_DCHK:  c = '{op: OP_NOP,  cond: C_DATE_EQ,   jt: S_EMIT,  jf: S_DSTEP};
            S_DSTEP: c = '{op: OP_STEP, cond: C_STEP_DONE, jt: S_EMIT,  jf: S_DSTEP};
            S_EMIT:  c = '{op: OP_EMIT, cond: C_OUT_FREE,  jt: S_WAIT,  jf: S_EMIT};
            default: c = '{op: OP_NOP,  cond: C_ALWAYS,    jt: S_WAIT,  jf: S_WAIT};
        endcase
        return c;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            M_FEB:                      len = leap ? DAYS_29 : DAYS_28;
            M_APR, M_JUN, M_SEP, M_NOV: len = DAYS_30;
            default:                    len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/cda_if.sv]
// Valid/ready channels for date requests and date results.
// Depends on cda_pkg for the payload types.
`timescale 1ns / 1ps

interface cda_in_if;
    import cda_pkg::*;
    logic     valid;
    logic     ready;
    t_in_data data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

interface cda_out_if;
    import cda_pkg::*;
    logic      valid;
    logic      ready;
    t_out_data data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/calendar_date_arithmetic.sv]
// Gregorian date add / difference engine run by a microcoded sequencer.
// Depends on cda_pkg (types, control store) and cda_if (request/result channels).
// Steps: accept, year quotient, year residue; add then walks one month boundary at a time,
// difference steps day by day, up to max(max_difference, 1) days; emit registers the result.
// One request in flight, a new one accepted only back in wait; an untaken result holds emit.
// Reset (sync, active low) idles the sequencer, empties the result slot, limit = 365.
`timescale 1ns / 1ps

module calendar_date_arithmetic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cda_in_if.sink                        i_req,
    cda_out_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cda_pkg::APB_AW-1:0]    paddr,
    input  logic [cda_pkg::APB_DW-1:0]    pwdata,
    output logic [cda_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import cda_pkg::*;

    t_step             r_step, n_step;
    t_ctrl             w_ctrl;
    logic              w_cond;

    logic [CNT_W-1:0]  r_maxdiff;
    logic [CNT_W-1:0]  w_limit;

    logic              r_cmd;
    logic [WDAY_W-1:0] r_d;
    logic [MONTH_W-1:0] r_m;
    logic [YEAR_W-1:0] r_y;
    logic [MOD_W-1:0]  r_ymod;
    logic [QUOT_W-1:0] r_q;
    logic [DAY_W-1:0]  r_fd, r_d2;
    logic [MONTH_W-1:0] r_fm, r_m2;
    logic [YEAR_W-1:0] r_fy, r_y2;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;

    t_out_data         r_out;
    logic              r_ovalid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_leap;
    logic [DAY_W-1:0]  w_len;
    logic [WDAY_W-1:0] w_base, w_nd;
    logic              w_over;
    logic [MONTH_W-1:0] w_nm;
    logic [YEAR_W-1:0] w_ny;
    logic [MOD_W-1:0]  w_nymod;
    logic              w_wrap;
    logic [32:0]       w_prod;
    logic [YEAR_W-1:0] w_rem;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic              w_hit;
    logic              w_eq_now, w_eq_next;

    // configuration port
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_MAX_DIFFERENCE[2])
                   ? {{(APB_DW-CNT_W){1'b0}}, r_maxdiff} : '0;
    assign w_limit = (r_maxdiff == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : r_maxdiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxdiff <= MAX_DIFFERENCE_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_MAX_DIFFERENCE[2]) begin
            r_maxdiff <= pwdata[CNT_W-1:0];
        end
    end

    // control store and step counter
    always_comb begin
        w_ctrl = ucode(r_step);
    end

    always_comb begin
        case (w_ctrl.cond)
            C_ALWAYS:    w_cond = 1'b1;
            C_REQ:       w_cond = i_req.valid;
            C_DIFF:      w_cond = (r_cmd == CMD_DIFF);
            C_FITS:      w_cond = !w_over;
            C_DATE_EQ:   w_cond = w_eq_now;
            C_STEP_DONE: w_cond = w_hit || w_eq_next;
            C_OUT_FREE:  w_cond = w_out_free;
            default:     w_cond = 1'b1;
        endcase
        n_step = w_cond ? w_ctrl.jt : w_ctrl.jf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign i_req.ready = (w_ctrl.op == OP_LOAD);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_ovalid || o_rsp.ready;

    // calendar datapath
    assign w_leap = (r_y[1:0] == 2'b00) && ((r_ymod != '0) || (r_y[3:0] == 4'b0000));
    assign w_len  = month_len(r_m, w_leap);
    assign w_base = (w_ctrl.op == OP_STEP) ? r_d + 1'b1 : r_d;
    assign w_over = w_base > {{(WDAY_W-DAY_W){1'b0}}, w_len};
    assign w_nd   = w_over ? w_base - {{(WDAY_W-DAY_W){1'b0}}, w_len} : w_base;

    always_comb begin
        w_nm    = r_m;
        w_ny    = r_y;
        w_nymod = r_ymod;
        w_wrap  = 1'b0;
        if (w_over) begin
            if (r_m >= M_DEC) begin
                w_nm = M_JAN;
                if (r_y == {YEAR_W{1'b1}}) begin
                    w_ny    = '0;
                    w_nymod = '0;
                    w_wrap  = 1'b1;
                end else begin
                    w_ny    = r_y + 1'b1;
                    w_nymod = (r_ymod == MOD25_LAST) ? '0 : r_ymod + 1'b1;
                end
            end else begin
                w_nm = r_m + 1'b1;
            end
        end
    end

    assign w_prod    = {{(33-YEAR_W){1'b0}}, r_y} * DIV25_MUL;
    assign w_rem     = r_y - {{(YEAR_W-QUOT_W){1'b0}}, r_q} * YEAR_DIV;
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_hit     = w_cnt_inc >= w_limit;
    assign w_eq_now  = (r_d == {{(WDAY_W-DAY_W){1'b0}}, r_d2}) && (r_m == r_m2)
                    && (r_y == r_y2);
    assign w_eq_next = (w_nd == {{(WDAY_W-DAY_W){1'b0}}, r_d2}) && (w_nm == r_m2)
                    && (w_ny == r_y2);

    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            OP_LOAD: begin
                if (w_accept) begin
                    r_cmd <= i_req.data.command;
                    r_fd  <= i_req.data.first_day;
                    r_fm  <= i_req.data.first_month;
                    r_fy  <= i_req.data.first_year;
                    r_d2  <= i_req.data.second_day;
                    r_m2  <= i_req.data.second_month;
                    r_y2  <= i_req.data.second_year;
                    r_m   <= i_req.data.first_month;
                    r_y   <= i_req.data.first_year;
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    if (i_req.data.command == CMD_DIFF) begin
                        r_d <= {{(WDAY_W-DAY_W){1'b0}}, i_req.data.first_day};
                    end else begin
                        r_d <= {{(WDAY_W-DAY_W){1'b0}}, i_req.data.first_day}
                             + {1'b0, i_req.data.days_to_add};
                    end
                end
            end
            OP_QUOT: r_q <= w_prod[DIV25_SHIFT +: QUOT_W];
            OP_MOD:  r_ymod <= w_rem[MOD_W-1:0];
            OP_WALK: begin
                if (w_over) begin
                    r_d    <= w_nd;
                    r_m    <= w_nm;
                    r_y    <= w_ny;
                    r_ymod <= w_nymod;
                    if (w_wrap) begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            OP_STEP: begin
                r_d    <= w_nd;
                r_m    <= w_nm;
                r_y    <= w_ny;
                r_ymod <= w_nymod;
                r_cnt  <= w_cnt_inc;
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    if (r_cmd == CMD_DIFF) begin
                        r_out <= '{result_day: r_fd, result_month: r_fm,
                                   result_year: r_fy, day_count: r_cnt,
                                   year_overflow: 1'b0};
                    end else begin
                        r_out <= '{result_day: r_d[DAY_W-1:0], result_month: r_m,
                                   result_year: r_y, day_count: '0,
                                   year_overflow: r_ovf};
                    end
                end
            end
            default: ;
        endcase
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_ctrl.op == OP_EMIT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    a_walk_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_AWALK && w_over) |=> (r_d < $past(r_d)))
        else $error("month walk did not reduce the day");

    a_ymod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_AWALK || r_step == S_DCHK || r_step == S_DSTEP) |-> (r_ymod <= MOD25_LAST))
        else $error("year residue out of range");

    a_diff_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.day_count != '0) |-> !o_rsp.data.year_overflow)
        else $error("difference result flagged overflow");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_EMIT && w_out_free) |=> (r_step == S_WAIT && r_ovalid))
        else $error("result not registered on emit");

endmodule

[tb/cda_result_checker.sv]
// Result checker for the calendar date block: watches the request, result and APB channels,
// predicts each result and compares it field by field.
// Depends on cda_pkg and the cda_if channels.
`timescale 1ns / 1ps

module cda_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cda_in_if                          i_req,
    cda_out_if                         i_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cda_pkg::APB_AW-1:0] paddr,
    input  logic [cda_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         o_fail_count,
    output int                         o_pending
);
    import cda_pkg::*;

    typedef struct {
        int unsigned day;
        int unsigned month;
        int unsigned year;
        bit          wrapped;
    } t_cal_date;

    t_out_data        expected_dates[$];
    t_out_data        got;
    t_out_data        want;
    logic [CNT_W-1:0] diff_limit;
    int               errors = 0;
    int               results_seen = 0;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            M_FEB:                      return leap_year(y) ? 29 : 28;
            M_APR, M_JUN, M_SEP, M_NOV: return 30;
            default:                    return 31;
        endcase
    endfunction

    // Take whole months off the day until it fits, carrying into month and year.
    function automatic t_cal_date roll_months(input t_cal_date p);
        while (p.day > days_in_month(p.month, p.year)) begin
            p.day   -= days_in_month(p.month, p.year);
            p.month += 1;
            if (p.month > 12) begin
                p.month = 1;
                if (p.year >= 65535) begin
                    p.year    = 0;
                    p.wrapped = 1'b1;
                end else begin
                    p.year += 1;
                end
            end
        end
        return p;
    endfunction

    function automatic t_out_data predict_date_result(input t_in_data r,
                                                     input logic [CNT_W-1:0] limit_reg);
        t_cal_date   p;
        int unsigned limit;
        int unsigned steps;
        t_out_data   o;
        p.day     = r.first_day;
        p.month   = r.first_month;
        p.year    = r.first_year;
        p.wrapped = 1'b0;
        steps     = 0;
        if (r.command == CMD_ADD) begin
            p.day += r.days_to_add;
            p = roll_months(p);
            o.result_day    = p.day[DAY_W-1:0];
            o.result_month  = p.month[MONTH_W-1:0];
            o.result_year   = p.year[YEAR_W-1:0];
            o.year_overflow = p.wrapped;
        end else begin
            limit = (limit_reg == '0) ? 1 : limit_reg;
            while (!(p.day == r.second_day && p.month == r.second_month
                     && p.year == r.second_year) && steps < limit) begin
                p.day += 1;
                p = roll_months(p);
                steps++;
            end
            o.result_day    = r.first_day;
            o.result_month  = r.first_month;
            o.result_year   = r.first_year;
            o.year_overflow = 1'b0;
        end
        o.day_count = steps[CNT_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 100)
            $display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned g, input int unsigned w);
        if (g != w)
            report_mismatch($sformatf("%s got %0d expected %0d", name, g, w));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_dates.delete();
            diff_limit = MAX_DIFFERENCE_RST;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (expected_dates.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_dates.pop_front();
                    check_field("result_day", got.result_day, want.result_day);
                    check_field("result_month", got.result_month, want.result_month);
                    check_field("result_year", got.result_year, want.result_year);
                    check_field("day_count", got.day_count, want.day_count);
                    check_field("year_overflow", got.year_overflow, want.year_overflow);
                end
                results_seen++;
            end
            if (i_req.valid && i_req.ready)
                expected_dates.push_back(predict_date_result(i_req.data, diff_limit));
            if (psel && penable && pwrite && pready && paddr == REG_MAX_DIFFERENCE)
                diff_limit = pwdata[CNT_W-1:0];
        end
        o_pending    <= expected_dates.size();
        o_fail_count <= errors;
    end

endmodule

[tb/testbench.sv]
// Top of the calendar date testbench: clock, reset, request and result traffic, APB writes
// of the difference limit, and the verdict.
// Depends on cda_pkg, cda_if, calendar_date_arithmetic and cda_result_checker.
`timescale 1ns / 1ps

module testbench;
    import cda_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned HOLD_CYCLES = 3000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    bit                src_burst = 1'b0;
    bit                snk_burst = 1'b0;

    logic [YEAR_W-1:0] notable_years [8] = '{16'd0, 16'd4, 16'd100, 16'd400,
                                              16'd1900, 16'd2000, 16'd65534, 16'd65535};

    cda_in_if  req_ch ();
    cda_out_if rsp_ch ();

    calendar_date_arithmetic dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cda_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Flip between idling and back-to-back stretches now and then.
    function automatic int unsigned next_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic t_in_data mk_req(input logic cmd, input int d1, input int m1,
                                        input int y1, input int d2, input int m2,
                                        input int y2, input int add);
        t_in_data r;
        r.command      = cmd;
        r.first_day    = DAY_W'(d1);
        r.first_month  = MONTH_W'(m1);
        r.first_year   = YEAR_W'(y1);
        r.second_day   = DAY_W'(d2);
        r.second_month = MONTH_W'(m2);
        r.second_year  = YEAR_W'(y2);
        r.days_to_add  = ADD_W'(add);
        return r;
    endfunction

    function automatic t_in_data random_request();
        t_in_data    r;
        int unsigned pick;
        r.command      = 1'($urandom_range(0, 1));
        r.first_day    = DAY_W'($urandom);
        r.first_month  = MONTH_W'($urandom);
        r.first_year   = YEAR_W'($urandom);
        r.second_day   = DAY_W'($urandom);
        r.second_month = MONTH_W'($urandom);
        r.second_year  = YEAR_W'($urandom);
        r.days_to_add  = ADD_W'($urandom);
        if ($urandom_range(0, 99) < 85) begin
            r.first_day   = DAY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(29, 31)
                                                               : $urandom_range(1, 28));
            r.first_month = MONTH_W'($urandom_range(1, 12));
            if ($urandom_range(0, 3) == 0)
                r.first_year = notable_years[3'($urandom_range(0, 7))];
            if (r.command == CMD_ADD) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    r.days_to_add = ADD_W'($urandom_range(0, 400));
                else if (pick < 9)
                    r.days_to_add = ADD_W'($urandom_range(0, 4000));
            end else begin
                r.second_day = DAY_W'(($urandom_range(0, 9) == 0) ? $urandom_range(29, 31)
                                                                  : $urandom_range(1, 28));
                if ($urandom_range(0, 3) == 0) begin
                    r.second_month = r.first_month;
                    r.second_year  = r.first_year;
                end else begin
                    r.second_month = MONTH_W'($urandom_range(1, 12));
                    r.second_year  = r.first_year + YEAR_W'($urandom_range(0, 1));
                end
            end
        end
        return r;
    endfunction

    task automatic send_request(input t_in_data r);
        int unsigned gap;
        gap = next_gap(src_burst);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_request(random_request());
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_max_difference(input logic [CNT_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[CNT_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_DIFFERENCE;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("calendar_date_arithmetic test failed");
        $finish;
    end

    // Result side; hold off once for a long stretch so the block backs up.
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        bit          held;
        taken = 0;
        held  = 1'b0;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = next_gap(snk_burst);
            if (!held && taken == 40) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    initial begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(mk_req(CMD_ADD, 1, 1, 2024, 0, 0, 0, 0));
        send_request(mk_req(CMD_ADD, 28, 2, 2024, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 28, 2, 2023, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 28, 2, 1900, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 28, 2, 2000, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 31, 12, 65535, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 31, 15, 65535, 31, 15, 65535, 65535));
        send_request(mk_req(CMD_ADD, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(CMD_ADD, 0, 3, 2021, 0, 0, 0, 5));
        send_request(mk_req(CMD_ADD, 31, 0, 2021, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 31, 13, 2021, 0, 0, 0, 1));
        send_request(mk_req(CMD_ADD, 31, 2, 2023, 0, 0, 0, 0));
        send_request(mk_req(CMD_ADD, 1, 1, 0, 0, 0, 0, 65535));
        send_request(mk_req(CMD_DIFF, 15, 6, 2024, 15, 6, 2024, 0));
        send_request(mk_req(CMD_DIFF, 1, 1, 2024, 1, 1, 2025, 0));
        send_request(mk_req(CMD_DIFF, 31, 12, 2023, 1, 1, 2024, 0));
        send_request(mk_req(CMD_DIFF, 31, 12, 65535, 1, 1, 0, 0));
        send_request(mk_req(CMD_DIFF, 2, 1, 2024, 1, 1, 2024, 0));
        send_request(mk_req(CMD_DIFF, 1, 2, 2023, 30, 2, 2023, 0));
        send_request(mk_req(CMD_DIFF, 1, 1, 2023, 1, 13, 2023, 0));
        send_request(mk_req(CMD_DIFF, 1, 1, 2023, 0, 2, 2023, 0));
        send_request(mk_req(CMD_DIFF, 31, 0, 2023, 1, 1, 2023, 0));
        send_request(mk_req(CMD_DIFF, 0, 5, 2023, 1, 5, 2023, 0));
        send_request(mk_req(CMD_DIFF, 31, 15, 65535, 31, 15, 65535, 65535));
        send_request(mk_req(CMD_DIFF, 1, 1, 2023, 31, 12, 2023, 0));
        run_random(300);
        drain_results();

        write_max_difference(10'd1023);
        run_random(300);
        drain_results();

        write_max_difference(10'd1);
        run_random(200);
        drain_results();

        write_max_difference(10'd0);
        run_random(150);
        drain_results();

        write_max_difference(CNT_W'($urandom_range(2, 1022)));
        run_random(300);
        drain_results();

        write_max_difference(MAX_DIFFERENCE_RST);
        run_random(250);
        drain_results();

        if (fail_count == 0 && pending == 0)
            $display("calendar_date_arithmetic test passed");
        else
            $display("calendar_date_arithmetic test failed");
        $finish;
    end

endmodule
